>>> hdl/iqalu_pkg.sv
// Shared types and constants for the integer / binary32 ALU.
// Holds opcodes, status codes, item structs, queue sizing and the back-end state type.
// No dependencies.
package iqalu_pkg;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_SUB, OP_MUL, OP_DIV, OP_ADDF, OP_SUBF, OP_MULF, OP_DIVF,
    OP_G, OP_GE, OP_L, OP_LE, OP_E, OP_NE, OP_GF, OP_GEF, OP_LF, OP_LEF, OP_EF, OP_NEF,
    OP_AND, OP_OR, OP_NOT, OP_I2I, OP_I2F, OP_I2C, OP_I2B, OP_F2I, OP_F2F, OP_F2C,
    OP_F2B, OP_C2I, OP_C2F, OP_C2C, OP_C2B, OP_B2I, OP_B2F, OP_B2C, OP_B2B
  } opcode_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [2:0] {
    CLS_SIMPLE, CLS_FADD, CLS_FMUL, CLS_FDIV, CLS_I2F, CLS_IDIV
  } op_class_t;

  typedef struct packed {
    op_class_t   cls;
    logic [5:0]  opcode;
    logic [31:0] a;
    logic [31:0] b;
  } work_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_PRE, BK_FDIV, BK_IDIV, BK_NORM
  } bk_state_t;

  // queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

endpackage

>>> hdl/iqalu_front.sv
// Front end: input register that accepts requests and classifies them by opcode.
// Feeds the work queue. Depends on iqalu_pkg.
module iqalu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  iqalu_pkg::in_item_t in_item,
  input  logic                q_full,
  output logic                q_push,
  output iqalu_pkg::work_t    q_item
);
  import iqalu_pkg::*;

  logic      valid_r, valid_nxt;
  work_t     item_r, item_nxt;
  op_class_t cls;
  logic      accept;

  always_comb begin
    unique case (opcode_t'(in_item.opcode)) inside
      OP_ADDF, OP_SUBF:         cls = CLS_FADD;
      OP_MULF:                  cls = CLS_FMUL;
      OP_DIVF:                  cls = CLS_FDIV;
      OP_DIV:                   cls = CLS_IDIV;
      OP_I2F, OP_C2F, OP_B2F:   cls = CLS_I2F;
      default:                  cls = CLS_SIMPLE;
    endcase
  end

  assign in_full = valid_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = valid_r & ~q_full;
  assign q_item  = item_r;

  always_comb begin
    valid_nxt = accept | (valid_r & q_full);
    item_nxt  = item_r;
    if (accept) begin
      item_nxt = '{cls: cls, opcode: in_item.opcode, a: in_item.operand_a,
                   b: in_item.operand_b};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

>>> hdl/iqalu_queue.sv
// Short work queue between the front end and the back end.
// Flop-based FIFO of classified requests. Depends on iqalu_pkg.
module iqalu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iqalu_pkg::work_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output iqalu_pkg::work_t head
);
  import iqalu_pkg::*;

  work_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == QFULL);
  assign valid   = (cnt_r != '0);
  assign head    = mem_r[rptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & valid;

  always_comb begin
    wptr_nxt = do_push ? QPTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? QPTR_W'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push & ~do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop & ~do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

>>> hdl/iqalu_back.sv
// Back end: executes requests from the work queue.
// Single-pass ops finish in the idle state as they are popped; float add/mul/div, int-to-float and int divide
// run through an iterative divider and normalizer. Depends on iqalu_pkg.
module iqalu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  iqalu_pkg::work_t     q_item,
  output logic                 q_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output iqalu_pkg::out_item_t res_item
);
  import iqalu_pkg::*;

  bk_state_t          state_r, state_nxt;
  logic [47:0]        m_r, m_nxt;
  logic signed [10:0] e_r, e_nxt, eb_r, eb_nxt;
  logic               s_r, s_nxt, zs_r, zs_nxt;
  logic [32:0]        rem_r, rem_nxt;
  logic [31:0]        dv_r, dv_nxt, q_r, q_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  // operand unpack
  logic [31:0]        a, b;
  logic               bs;
  logic [7:0]         ea8, eb8;
  logic [23:0]        ma, mb;
  logic signed [10:0] ea_e, eb_e;
  logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  // single-pass results
  logic [31:0]        simple_r;
  logic [1:0]         simple_st;
  logic               f_eq, f_lt, f_gt, f_un;
  logic [31:0]        trunc;
  logic [7:0]         fe;

  // float add alignment
  logic               swap;
  logic [31:0]        big, sml;
  logic [7:0]         ebig, esml, dsh;
  logic [23:0]        mbig, msml;
  logic [47:0]        sml_full, sml_sh, big_full, add_m;
  logic               sml_st, eff_sub, add_nan, add_inf;

  logic [47:0]        prod;
  logic [31:0]        i2f_mag;

  // iterative steps
  logic               fd_ge, id_ge;
  logic [32:0]        fd_diff, id_trial, id_diff;
  logic [31:0]        id_q;
  logic signed [10:0] rsh;
  logic [47:0]        m_rsh;
  logic               rsh_lost;
  logic               rnd_inc;
  logic [24:0]        rnd;
  logic signed [10:0] e_rnd;
  logic [31:0]        rnd_word;

  function automatic logic slt(input logic [31:0] x, input logic [31:0] y);
    slt = (x ^ 32'h8000_0000) < (y ^ 32'h8000_0000);
  endfunction

  function automatic logic [31:0] to_char(input logic [31:0] w);
    to_char = {{24{w[7]}}, w[7:0]};
  endfunction

  function automatic logic [31:0] fkey(input logic [31:0] w);
    fkey = w[31] ? ~w : {1'b1, w[30:0]};
  endfunction

  assign a      = q_item.a;
  assign b      = q_item.b;
  assign bs     = b[31] ^ (q_item.opcode == OP_SUBF);
  assign ea8    = a[30:23];
  assign eb8    = b[30:23];
  assign ma     = {|ea8, a[22:0]};
  assign mb     = {|eb8, b[22:0]};
  assign ea_e   = $signed({3'b000, ea8[7:1], ea8[0] | ~|ea8});
  assign eb_e   = $signed({3'b000, eb8[7:1], eb8[0] | ~|eb8});
  assign a_nan  = (&ea8) & (|a[22:0]);
  assign b_nan  = (&eb8) & (|b[22:0]);
  assign a_inf  = (&ea8) & ~(|a[22:0]);
  assign b_inf  = (&eb8) & ~(|b[22:0]);
  assign a_zero = ~|a[30:0];
  assign b_zero = ~|b[30:0];

  // float compares and float-to-int truncation
  always_comb begin
    f_un  = a_nan | b_nan;
    f_eq  = ~f_un & ((a == b) | (a_zero & b_zero));
    f_lt  = ~f_un & ~f_eq & (fkey(a) < fkey(b));
    f_gt  = ~f_un & ~f_eq & (fkey(b) < fkey(a));
    fe    = ea8;
    if (fe < 8'd127) begin
      trunc = '0;
    end else if (fe <= 8'd150) begin
      trunc = {8'b0, 1'b1, a[22:0]} >> (8'd150 - fe);
    end else begin
      trunc = {8'b0, 1'b1, a[22:0]} << (fe - 8'd150);
    end
  end

  always_comb begin
    simple_r  = '0;
    simple_st = ST_OK;
    case (opcode_t'(q_item.opcode)) inside
      OP_ADD:  simple_r = a + b;
      OP_SUB:  simple_r = a - b;
      OP_MUL:  simple_r = a * b;
      OP_G:    simple_r = {31'b0, slt(b, a)};
      OP_GE:   simple_r = {31'b0, ~slt(a, b)};
      OP_L:    simple_r = {31'b0, slt(a, b)};
      OP_LE:   simple_r = {31'b0, ~slt(b, a)};
      OP_E:    simple_r = {31'b0, a == b};
      OP_NE:   simple_r = {31'b0, a != b};
      OP_GF:   simple_r = {31'b0, f_gt};
      OP_GEF:  simple_r = {31'b0, f_gt | f_eq};
      OP_LF:   simple_r = {31'b0, f_lt};
      OP_LEF:  simple_r = {31'b0, f_lt | f_eq};
      OP_EF:   simple_r = {31'b0, f_eq};
      OP_NEF:  simple_r = {31'b0, ~f_eq};
      OP_AND:  simple_r = {31'b0, (a != '0) & (b != '0)};
      OP_OR:   simple_r = {31'b0, (a != '0) | (b != '0)};
      OP_NOT:  simple_r = {31'b0, a == '0};
      OP_I2I, OP_F2F, OP_C2I, OP_C2C, OP_B2I, OP_B2B: simple_r = a;
      OP_I2C, OP_B2C: simple_r = to_char(a);
      OP_I2B, OP_C2B: simple_r = {31'b0, a != '0};
      OP_F2B:  simple_r = {31'b0, ~a_zero};
      OP_F2I: begin
        if (a_nan || (!a[31] && fe >= 8'd158)) begin
          simple_r  = 32'h7FFF_FFFF;
          simple_st = ST_SAT;
        end else if (fe >= 8'd158) begin
          // exactly minus two to the 31st converts cleanly
          simple_r  = 32'h8000_0000;
          simple_st = (fe == 8'd158 && a[22:0] == '0) ? ST_OK : ST_SAT;
        end else begin
          simple_r = a[31] ? (32'd0 - trunc) : trunc;
        end
      end
      OP_F2C: begin
        if (a_nan || (!a[31] && (fe >= 8'd158 || trunc >= 32'd128))) begin
          simple_r  = 32'd127;
          simple_st = ST_SAT;
        end else if (a[31] && (fe >= 8'd158 || trunc >= 32'd129)) begin
          simple_r  = 32'hFFFF_FF80;
          simple_st = ST_SAT;
        end else begin
          simple_r = to_char(a[31] ? (32'd0 - trunc) : trunc);
        end
      end
      default: simple_r = '0;
    endcase
  end

  // float add: order by magnitude, align the smaller operand, fold lost bits into sticky
  always_comb begin
    swap     = b[30:0] > a[30:0];
    big      = swap ? {bs, b[30:0]} : a;
    sml      = swap ? a : {bs, b[30:0]};
    ebig     = {big[30:24], big[23] | ~|big[30:23]};
    esml     = {sml[30:24], sml[23] | ~|sml[30:23]};
    mbig     = {|big[30:23], big[22:0]};
    msml     = {|sml[30:23], sml[22:0]};
    dsh      = ebig - esml;
    big_full = {1'b0, mbig, 23'b0};
    sml_full = {1'b0, msml, 23'b0};
    if (dsh >= 8'd48) begin
      sml_sh = '0;
      sml_st = |sml_full;
    end else begin
      sml_sh = sml_full >> dsh;
      sml_st = (sml_sh << dsh) != sml_full;
    end
    eff_sub = big[31] ^ sml[31];
    add_m   = eff_sub ? (big_full - (sml_sh | {47'b0, sml_st}))
                      : (big_full + (sml_sh | {47'b0, sml_st}));
    add_nan = a_nan | b_nan | (a_inf & b_inf & (a[31] != bs));
    add_inf = a_inf | b_inf;
  end

  assign prod    = ma * mb;
  assign i2f_mag = a[31] ? (32'd0 - a) : a;

  // divider steps
  always_comb begin
    fd_ge    = rem_r >= {1'b0, dv_r};
    fd_diff  = fd_ge ? (rem_r - {1'b0, dv_r}) : rem_r;
    id_trial = {rem_r[31:0], q_r[31]};
    id_ge    = id_trial >= {1'b0, dv_r};
    id_diff  = id_ge ? (id_trial - {1'b0, dv_r}) : id_trial;
    id_q     = {q_r[30:0], id_ge};
  end

  // denormalizing shift and round to nearest even
  always_comb begin
    rsh = 11'sd1 - e_r;
    if (rsh > 11'sd47) begin
      m_rsh    = '0;
      rsh_lost = |m_r;
    end else begin
      m_rsh    = m_r >> rsh[5:0];
      rsh_lost = (m_rsh << rsh[5:0]) != m_r;
    end
    rnd_inc = m_r[23] & ((|m_r[22:0]) | m_r[24]);
    rnd     = {1'b0, m_r[47:24]} + {24'b0, rnd_inc};
    e_rnd   = rnd[24] ? (e_r + 11'sd1) : e_r;
    if (e_rnd >= 11'sd255) begin
      rnd_word = {s_r, 8'hFF, 23'b0};
    end else if (rnd[24] | rnd[23]) begin
      rnd_word = {s_r, e_rnd[7:0], rnd[22:0]};
    end else begin
      rnd_word = {s_r, 8'd0, rnd[22:0]};
    end
  end

  assign q_pop = (state_r == BK_IDLE) & q_valid & ~res_full;

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    e_nxt     = e_r;
    eb_nxt    = eb_r;
    s_nxt     = s_r;
    zs_nxt    = zs_r;
    rem_nxt   = rem_r;
    dv_nxt    = dv_r;
    q_nxt     = q_r;
    cnt_nxt   = cnt_r;
    res_push  = 1'b0;
    res_item  = '{result_word: '0, status: ST_OK};
    unique case (state_r)
      BK_IDLE: begin
        if (q_pop) begin
          case (q_item.cls)
            CLS_FADD: begin
              if (add_nan) begin
                res_push = 1'b1;
                res_item.result_word = QNAN;
              end else if (add_inf) begin
                res_push = 1'b1;
                res_item.result_word = {a_inf ? a[31] : bs, 8'hFF, 23'b0};
              end else begin
                m_nxt     = add_m;
                e_nxt     = $signed({3'b000, ebig}) + 11'sd1;
                s_nxt     = big[31];
                zs_nxt    = ~eff_sub & big[31];
                state_nxt = BK_NORM;
              end
            end
            CLS_FMUL: begin
              if (a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero)) begin
                res_push = 1'b1;
                res_item.result_word = QNAN;
              end else if (a_inf | b_inf) begin
                res_push = 1'b1;
                res_item.result_word = {a[31] ^ b[31], 8'hFF, 23'b0};
              end else begin
                m_nxt     = prod;
                e_nxt     = ea_e + eb_e - 11'sd126;
                s_nxt     = a[31] ^ b[31];
                zs_nxt    = a[31] ^ b[31];
                state_nxt = BK_NORM;
              end
            end
            CLS_FDIV: begin
              if (a_nan | b_nan | (a_inf & b_inf) | (a_zero & b_zero)) begin
                res_push = 1'b1;
                res_item.result_word = QNAN;
              end else if (a_inf | b_zero) begin
                res_push = 1'b1;
                res_item.result_word = {a[31] ^ b[31], 8'hFF, 23'b0};
              end else if (b_inf | a_zero) begin
                res_push = 1'b1;
                res_item.result_word = {a[31] ^ b[31], 31'b0};
              end else begin
                rem_nxt   = {9'b0, ma};
                dv_nxt    = {8'b0, mb};
                e_nxt     = ea_e;
                eb_nxt    = eb_e;
                s_nxt     = a[31] ^ b[31];
                zs_nxt    = a[31] ^ b[31];
                state_nxt = BK_PRE;
              end
            end
            CLS_I2F: begin
              m_nxt     = {i2f_mag, 16'b0};
              e_nxt     = 11'sd158;
              s_nxt     = a[31];
              zs_nxt    = 1'b0;
              state_nxt = BK_NORM;
            end
            CLS_IDIV: begin
              if (b == '0) begin
                res_push = 1'b1;
                res_item = '{result_word: '0, status: ST_DIV0};
              end else begin
                rem_nxt   = '0;
                q_nxt     = a[31] ? (32'd0 - a) : a;
                dv_nxt    = b[31] ? (32'd0 - b) : b;
                s_nxt     = a[31] ^ b[31];
                cnt_nxt   = '0;
                state_nxt = BK_IDIV;
              end
            end
            default: begin
              res_push = 1'b1;
              res_item = '{result_word: simple_r, status: simple_st};
            end
          endcase
        end
      end
      BK_PRE: begin
        // bring both significands up to a leading one before dividing
        if (!rem_r[23]) begin
          rem_nxt = {rem_r[31:0], 1'b0};
          e_nxt   = e_r - 11'sd1;
        end
        if (!dv_r[23]) begin
          dv_nxt = {dv_r[30:0], 1'b0};
          eb_nxt = eb_r - 11'sd1;
        end
        if (rem_r[23] & dv_r[23]) begin
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = BK_FDIV;
        end
      end
      BK_FDIV: begin
        rem_nxt = {fd_diff[31:0], 1'b0};
        q_nxt   = {q_r[30:0], fd_ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd26) begin
          m_nxt     = {q_r[25:0], fd_ge, 20'b0, |fd_diff};
          e_nxt     = e_r - eb_r + 11'sd127;
          state_nxt = BK_NORM;
        end
      end
      BK_IDIV: begin
        rem_nxt = id_diff;
        q_nxt   = id_q;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          res_push  = 1'b1;
          res_item  = '{result_word: s_r ? (32'd0 - id_q) : id_q, status: ST_OK};
          state_nxt = BK_IDLE;
        end
      end
      BK_NORM: begin
        if (m_r == '0) begin
          res_push  = 1'b1;
          res_item.result_word = {zs_r, 31'b0};
          state_nxt = BK_IDLE;
        end else if (e_r < 11'sd1) begin
          m_nxt = m_rsh | {47'b0, rsh_lost};
          e_nxt = 11'sd1;
        end else if (m_r[47] || e_r == 11'sd1) begin
          res_push  = 1'b1;
          res_item.result_word = rnd_word;
          state_nxt = BK_IDLE;
        end else begin
          m_nxt = {m_r[46:0], 1'b0};
          e_nxt = e_r - 11'sd1;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    e_r   <= e_nxt;
    eb_r  <= eb_nxt;
    s_r   <= s_nxt;
    zs_r  <= zs_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

>>> hdl/int_and_float_quad_alu_unit.sv
// Integer and binary32 ALU: one request (opcode, two words) gives one result (word, status).
// Integer add/sub/mul, logic, compares, float compares and most casts finish as they are popped in
// the back end, so they stream at one request per clock while the result queue is not full;
// a result passes the input register, the work queue and the result queue on its way out.
// Integer divide holds the back end while it forms one quotient bit per cycle. Float add,
// mul and int-to-float pass a shared normalizer that shifts one bit per cycle. Float divide
// first pre-normalizes both significands, then forms quotient bits and is normalized too.
// Depends on iqalu_pkg, iqalu_front, iqalu_queue and iqalu_back.
module int_and_float_quad_alu_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  iqalu_pkg::in_item_t  in_item,
  input  logic                 out_pop,
  output logic                 out_empty,
  output iqalu_pkg::out_item_t out_item
);
  import iqalu_pkg::*;

  logic      fq_push, fq_full, q_valid, q_pop;
  work_t     fq_item, q_head;
  logic      res_push, res_full;
  out_item_t res_item;

  out_item_t          omem_r [QDEPTH];
  logic [QPTR_W-1:0]  owp_r, owp_nxt, orp_r, orp_nxt;
  logic [QCNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic               o_wr, o_rd;

  iqalu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (fq_full),
    .q_push  (fq_push),
    .q_item  (fq_item)
  );

  iqalu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fq_item),
    .full      (fq_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  iqalu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_item (res_item)
  );

  // result queue
  assign res_full  = (ocnt_r == QFULL);
  assign out_empty = (ocnt_r == '0);
  assign out_item  = omem_r[orp_r];
  assign o_wr      = res_push & ~res_full;
  assign o_rd      = out_pop & ~out_empty;

  always_comb begin
    owp_nxt  = o_wr ? QPTR_W'(owp_r + 1'b1) : owp_r;
    orp_nxt  = o_rd ? QPTR_W'(orp_r + 1'b1) : orp_r;
    ocnt_nxt = ocnt_r;
    if (o_wr & ~o_rd) begin
      ocnt_nxt = QCNT_W'(ocnt_r + 1'b1);
    end else if (o_rd & ~o_wr) begin
      ocnt_nxt = QCNT_W'(ocnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_wr) begin
      omem_r[owp_r] <= res_item;
    end
  end

endmodule
